FILE: sv/acl_pkg.sv
// ============================================================================
// acl_pkg
// Shared constants, types and helper functions for the fully associative
// cache tag store with LRU or FIFO replacement.
// ============================================================================
package acl_pkg;

    // Store geometry.
    localparam int ENTRIES    = 16;
    localparam int ADDR_WIDTH = 32;

    // Fixed field widths of the access and result items.
    localparam int FIELD_W = 32;
    localparam int CNT_W   = 32;

    // The tag is the low address bits, never wider than the address field.
    localparam int TAG_W  = (ADDR_WIDTH < FIELD_W) ? ADDR_WIDTH : FIELD_W;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int AGE_W  = IDX_W;
    localparam int FILL_W = $clog2(ENTRIES + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;
    localparam int CMP_W      = (FILL_W > CFG_DATA_W) ? FILL_W : CFG_DATA_W;

    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 1'b1;

    localparam logic [CFG_DATA_W-1:0] ENTRIES_IN_USE_RST = 5'd16;

    // Replacement policy codes.
    typedef enum logic
    {
        MODE_LRU  = 1'b0,
        MODE_FIFO = 1'b1
    } mode_t;

    // Controller states.
    typedef enum logic [1:0]
    {
        S_IDLE,
        S_LOOKUP,
        S_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed
    {
        logic capture;
        logic lookup;
        logic commit;
    } acl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed
    {
        logic out_free;
    } acl_status_t;

    // Index of the lowest set bit of a per-entry vector, zero when none is set.
    function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
        logic [IDX_W-1:0] idx;
        logic             found;
        idx   = '0;
        found = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (vec[i] && !found)
            begin
                idx   = IDX_W'(i);
                found = 1'b1;
            end
        end
        return idx;
    endfunction

endpackage

FILE: sv/acl_ctrl.sv
// ============================================================================
// acl_ctrl
// Controller state machine: takes one access, runs the lookup and the
// update, and holds the update until the result register is free.
// ============================================================================
module acl_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  acl_pkg::acl_status_t status,
    output acl_pkg::acl_cmd_t    cmd
);
    import acl_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.lookup  = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            S_LOOKUP:
            begin
                cmd.lookup = 1'b1;
            end
            S_UPDATE:
            begin
                cmd.commit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: sv/acl_datapath.sv
// ============================================================================
// acl_datapath
// Tag store, valid bits, ages, fill count, statistics counters,
// configuration registers and the result register.
// ============================================================================
module acl_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  acl_pkg::acl_cmd_t                    cmd,
    output acl_pkg::acl_status_t                 status,
    input  logic                                 cfg_we,
    input  logic [acl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [acl_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [acl_pkg::FIELD_W-1:0]          access_address,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 was_hit,
    output logic                                 evicted_valid,
    output logic [acl_pkg::FIELD_W-1:0]          evicted_address,
    output logic [acl_pkg::CNT_W-1:0]            total_hits,
    output logic [acl_pkg::CNT_W-1:0]            total_misses
);
    import acl_pkg::*;

    // Configuration registers.
    mode_t                 mode_reg;
    logic [CFG_DATA_W-1:0] cap_cfg_reg;

    // Store state.
    logic [TAG_W-1:0]  tag_reg   [ENTRIES];
    logic [ENTRIES-1:0] valid_reg;
    logic [ENTRIES-1:0] valid_next;
    logic [AGE_W-1:0]  age_reg   [ENTRIES];
    logic [AGE_W-1:0]  age_next  [ENTRIES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [CNT_W-1:0]  hits_reg;
    logic [CNT_W-1:0]  hits_next;
    logic [CNT_W-1:0]  misses_reg;
    logic [CNT_W-1:0]  misses_next;

    // Access in flight and lookup results.
    logic [TAG_W-1:0] addr_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    logic [IDX_W-1:0] slot_reg;
    logic             evict_reg;

    // Result register.
    logic             out_valid_reg;
    logic             was_hit_reg;
    logic             ev_valid_reg;
    logic [FIELD_W-1:0] ev_addr_reg;
    logic [FIELD_W-1:0] ev_addr_next;

    // Lookup logic.
    logic [ENTRIES-1:0] match_vec;
    logic [ENTRIES-1:0] oldest_vec;
    logic [ENTRIES-1:0] free_vec;
    logic [CMP_W-1:0]   cap_eff;
    logic [AGE_W-1:0]   oldest_age;
    logic               need_evict;
    logic [AGE_W-1:0]   hit_age;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_LRU;
            cap_cfg_reg <= ENTRIES_IN_USE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_REPLACE_MODE:   mode_reg    <= mode_t'(cfg_data[0]);
                CFG_ENTRIES_IN_USE: cap_cfg_reg <= cfg_data;
                default:            mode_reg    <= mode_reg;
            endcase
        end
    end

    // Effective capacity: zero acts as one, anything above the store size
    // acts as the store size.
    always_comb
    begin
        cap_eff = CMP_W'(cap_cfg_reg);
        if (cap_eff == '0)
        begin
            cap_eff = CMP_W'(1);
        end
        else if (cap_eff > CMP_W'(ENTRIES))
        begin
            cap_eff = CMP_W'(ENTRIES);
        end
    end

    // Parallel tag compare and victim selection. Valid entries hold the
    // distinct ages 0 to fill-1, so the oldest entry is the one whose age
    // equals fill-1.
    assign oldest_age = AGE_W'(fill_reg - FILL_W'(1));
    assign need_evict = (CMP_W'(fill_reg) >= cap_eff);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i]  = valid_reg[i] && (tag_reg[i] == addr_reg);
            oldest_vec[i] = valid_reg[i] && (age_reg[i] == oldest_age);
            free_vec[i]   = !valid_reg[i];
        end
    end

    // Access capture and lookup registers.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            addr_reg <= access_address[TAG_W-1:0];
        end
        if (cmd.lookup)
        begin
            hit_reg     <= |match_vec;
            hit_idx_reg <= first_set(match_vec);
            slot_reg    <= need_evict ? first_set(oldest_vec) : first_set(free_vec);
            evict_reg   <= !(|match_vec) && need_evict;
        end
    end

    // Store update for the access being committed.
    assign hit_age = age_reg[hit_idx_reg];

    always_comb
    begin
        valid_next   = valid_reg;
        age_next     = age_reg;
        fill_next    = fill_reg;
        hits_next    = hits_reg;
        misses_next  = misses_reg;
        ev_addr_next = '0;
        if (cmd.commit)
        begin
            if (hit_reg)
            begin
                if (hits_reg != '1)
                begin
                    hits_next = hits_reg + CNT_W'(1);
                end
                // In LRU order the hit entry becomes newest and the more
                // recent entries each grow one older.
                if (mode_reg == MODE_LRU)
                begin
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (valid_reg[i] && (age_reg[i] < hit_age))
                        begin
                            age_next[i] = age_reg[i] + AGE_W'(1);
                        end
                    end
                    age_next[hit_idx_reg] = '0;
                end
            end
            else
            begin
                if (misses_reg != '1)
                begin
                    misses_next = misses_reg + CNT_W'(1);
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (valid_reg[i])
                    begin
                        age_next[i] = age_reg[i] + AGE_W'(1);
                    end
                end
                age_next[slot_reg]   = '0;
                valid_next[slot_reg] = 1'b1;
                if (evict_reg)
                begin
                    ev_addr_next = FIELD_W'(tag_reg[slot_reg]);
                end
                else
                begin
                    fill_next = fill_reg + FILL_W'(1);
                end
            end
        end
    end

    // Control state of the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            fill_reg   <= '0;
            hits_reg   <= '0;
            misses_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                age_reg[i] <= '0;
            end
        end
        else
        begin
            valid_reg  <= valid_next;
            fill_reg   <= fill_next;
            hits_reg   <= hits_next;
            misses_reg <= misses_next;
            age_reg    <= age_next;
        end
    end

    // Tag store write on a miss.
    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit_reg)
        begin
            tag_reg[slot_reg] <= addr_reg;
        end
    end

    // Result register: loaded on commit, emptied by an output transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            was_hit_reg  <= hit_reg;
            ev_valid_reg <= evict_reg;
            ev_addr_reg  <= ev_addr_next;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;

    assign out_valid       = out_valid_reg;
    assign was_hit         = was_hit_reg;
    assign evicted_valid   = ev_valid_reg;
    assign evicted_address = ev_addr_reg;
    assign total_hits      = hits_reg;
    assign total_misses    = misses_reg;

endmodule

FILE: sv/assoc_cache_lru_fifo_replace_unit.sv
// ============================================================================
// assoc_cache_lru_fifo_replace_unit
// Fully associative tag store of up to sixteen addresses with least
// recently used or first in first out replacement and hit/miss counters.
// ============================================================================
// Usage:
// An access address arrives on the input channel (in_valid, in_ready,
// access_address). Each access produces exactly one result on the output
// channel (out_valid, out_ready): hit flag, eviction flag and address, and
// the saturating hit and miss totals including this access.
// An access passes through address capture, the parallel tag compare and
// victim selection, and the store update that also loads the result
// register. The result is shown the cycle after the update; the store
// handles one access at a time and takes no new access until the last one
// has been updated.
// The result register separates the two sides: while a result waits for
// out_ready the block still takes the next access and looks it up, and that
// access is held in its update step until the result register is free.
// Reset clears all valid bits, ages, the fill count and both counters, and
// sets LRU mode with a capacity of sixteen entries. Configuration writes
// through cfg_we, cfg_index and cfg_data take effect on the next clock.
// ============================================================================
module assoc_cache_lru_fifo_replace_unit
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [acl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [acl_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [acl_pkg::FIELD_W-1:0]    access_address,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           was_hit,
    output logic                           evicted_valid,
    output logic [acl_pkg::FIELD_W-1:0]    evicted_address,
    output logic [acl_pkg::CNT_W-1:0]      total_hits,
    output logic [acl_pkg::CNT_W-1:0]      total_misses
);
    import acl_pkg::*;

    acl_cmd_t    cmd;
    acl_status_t status;

    // Sequencing of each access.
    acl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Store, counters and result register.
    acl_datapath u_datapath
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .access_address  (access_address),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .was_hit         (was_hit),
        .evicted_valid   (evicted_valid),
        .evicted_address (evicted_address),
        .total_hits      (total_hits),
        .total_misses    (total_misses)
    );

endmodule

FILE: sv/acl_checker.sv
// ============================================================================
// acl_checker
// Port-level checks on the cache replacement unit, bound to the top level.
// ============================================================================
module acl_checker
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  logic                           was_hit,
    input  logic                           evicted_valid,
    input  logic [acl_pkg::FIELD_W-1:0]    evicted_address,
    input  logic [acl_pkg::CNT_W-1:0]      total_hits,
    input  logic [acl_pkg::CNT_W-1:0]      total_misses
);
    import acl_pkg::*;

    // A hit never evicts anything.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && was_hit |-> !evicted_valid)
    else $error("eviction reported on a hit");

    // The evicted address reads zero when nothing was evicted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !evicted_valid |-> evicted_address == '0)
    else $error("evicted address not zero without an eviction");

    // Only one access is in the store at a time: no transfer straight after one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input ready in the cycle after an input transfer");

    // A stalled result holds its counts.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable(total_hits) && $stable(total_misses))
    else $error("stalled result changed");

endmodule

bind assoc_cache_lru_fifo_replace_unit acl_checker u_acl_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .was_hit         (was_hit),
    .evicted_valid   (evicted_valid),
    .evicted_address (evicted_address),
    .total_hits      (total_hits),
    .total_misses    (total_misses)
);
